@@ hdl/mtwg_pkg.sv @@
// Shared constants and controller/datapath interface types for the MT19937 word generator.
package mtwg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;

    localparam int IDX_W   = $clog2(STATE_WORDS);
    localparam int OFF_MOD = TWIST_OFFSET % STATE_WORDS;

    localparam logic [31:0] SEED_RESET   = 32'd5489;
    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam int          INIT_SHIFT   = 30;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] UPPER_BIT    = 32'h8000_0000;
    localparam logic [31:0] LOWER_BITS   = 32'h7FFF_FFFF;
    localparam int          TEMPER_U     = 11;
    localparam int          TEMPER_S     = 7;
    localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
    localparam int          TEMPER_T     = 15;
    localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;
    localparam int          TEMPER_L     = 18;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [31:0]      t_word;

    localparam t_idx LAST_IDX = IDX_W'(STATE_WORDS - 1);

    // Commands from the controller to the datapath, one per state action.
    typedef struct packed {
        logic bld_first;  // write the seed to entry 0
        logic bld_mul;    // multiply step of the seeding recurrence
        logic bld_add;    // add the index and write the entry
        logic pos_clear;  // read position back to zero
        logic tw_pre;     // read entry 0 ahead of the twist pass
        logic tw_load;    // capture entry 0 as the current word
        logic tw_read;    // read the next and the offset entries
        logic tw_write;   // write the twisted entry
        logic out_read;   // read the entry at the read position
        logic out_load;   // temper into the output register, advance position
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;   // working index is at the last entry
        logic pos_zero;   // read position is zero
        logic out_free;   // output register can take a new word
    } t_dp_stat;

endpackage

@@ hdl/mt19937_word_generator.sv @@
// Top level of the MT19937 word generator: controller and datapath.
//
//  Channel   Direction  Handshake          Payload
//  request   in         i_valid / o_stall  i_restart
//  result    out        o_valid / i_stall  o_random_word[31:0]
//  config    in         i_cfg_wen          i_cfg_wdata[31:0] (seed)
//
// A request that needs no twist passes S_OUT_RD and S_OUT_LD, which waits for a free result
// register; the next transfer is taken once the controller is back in S_IDLE.
// When the read position is zero, a twist pass comes first: S_TW_PRE and S_TW_LOAD, then
// S_TW_RD and S_TW_WR per entry, set by the single-port table write with its registered reads.
// A restart, and the first request after reset, first reseed the table: entry 0 takes the
// seed, then each further entry takes one multiply and one add.
// Reset clears the control state and loads the seed 5489; the table is built on first use.
// The block takes one request at a time; a stalled result does not block the next transfer.
module mt19937_word_generator
    import mtwg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_random_word
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mtwg_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_restart (i_restart),
        .o_stall   (o_stall),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    mtwg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_random_word (o_random_word)
    );

endmodule

@@ hdl/mtwg_dp.sv @@
// Datapath: state table memory, seeding and twist arithmetic, tempering and output register.
module mtwg_dp
    import mtwg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wen,
    input  t_word    i_cfg_wdata,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    input  logic     i_stall,
    output logic     o_valid,
    output t_word    o_random_word
);

    t_word r_mem [STATE_WORDS];

    t_word r_seed;
    t_word r_prev;
    t_word r_prod;
    t_word r_cur;
    t_word r_rd_a;
    t_word r_rd_b;
    t_word r_word;
    logic  r_out_valid;
    t_idx  r_idx;
    t_idx  r_pos;

    t_idx  n_idx;
    t_idx  n_pos;
    t_idx  idx_plus_one;
    t_idx  idx_plus_off;
    t_idx  rd_a_addr;
    logic [IDX_W:0] off_sum;
    t_word init_val;
    t_word twist_y;
    t_word twist_z;
    t_word twist_val;
    t_word wr_data;
    logic  wr_en;

    function automatic t_word temper(input t_word v);
        t_word t;
        t = v ^ (v >> TEMPER_U);
        t = t ^ ((t << TEMPER_S) & TEMPER_B);
        t = t ^ ((t << TEMPER_T) & TEMPER_C);
        t = t ^ (t >> TEMPER_L);
        return t;
    endfunction

    // Circular neighbor addresses for the twist recurrence.
    assign idx_plus_one = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign off_sum      = {1'b0, r_idx} + (IDX_W+1)'(OFF_MOD);
    assign idx_plus_off = (off_sum >= (IDX_W+1)'(STATE_WORDS))
                        ? IDX_W'(off_sum - (IDX_W+1)'(STATE_WORDS))
                        : IDX_W'(off_sum);

    always_comb begin
        rd_a_addr = r_pos;
        if (i_cmd.tw_pre) begin
            rd_a_addr = '0;
        end else if (i_cmd.tw_read) begin
            rd_a_addr = idx_plus_one;
        end
    end

    assign init_val  = r_prod + 32'(r_idx);
    assign twist_y   = (r_cur & UPPER_BIT) | (r_rd_a & LOWER_BITS);
    assign twist_z   = (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);
    assign twist_val = r_rd_b ^ twist_z;

    always_comb begin
        wr_en   = i_cmd.bld_first | i_cmd.bld_add | i_cmd.tw_write;
        wr_data = twist_val;
        if (i_cmd.bld_first) begin
            wr_data = r_seed;
        end else if (i_cmd.bld_add) begin
            wr_data = init_val;
        end
    end

    // Table memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_cmd.bld_first ? t_idx'(0) : r_idx] <= wr_data;
        end
        if (i_cmd.tw_pre || i_cmd.tw_read || i_cmd.out_read) begin
            r_rd_a <= r_mem[rd_a_addr];
        end
        if (i_cmd.tw_read) begin
            r_rd_b <= r_mem[idx_plus_off];
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.bld_first) begin
            n_idx = IDX_W'(1);
        end else if (i_cmd.tw_pre) begin
            n_idx = '0;
        end else if ((i_cmd.bld_add || i_cmd.tw_write) && r_idx != LAST_IDX) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (i_cmd.pos_clear) begin
            n_pos = '0;
        end else if (i_cmd.out_load) begin
            n_pos = (r_pos == LAST_IDX) ? '0 : r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed      <= SEED_RESET;
            r_pos       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_seed <= i_cfg_wdata;
            end
            r_pos <= n_pos;
            r_idx <= n_idx;
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.bld_first) begin
            r_prev <= r_seed;
        end else if (i_cmd.bld_add) begin
            r_prev <= init_val;
        end
        if (i_cmd.bld_mul) begin
            r_prod <= INIT_MULT * (r_prev ^ (r_prev >> INIT_SHIFT));
        end
        if (i_cmd.tw_load || i_cmd.tw_write) begin
            r_cur <= r_rd_a;
        end
        if (i_cmd.out_load) begin
            r_word <= temper(r_rd_a);
        end
    end

    assign o_stat.idx_last = (r_idx == LAST_IDX);
    assign o_stat.pos_zero = (r_pos == '0);
    assign o_stat.out_free = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_random_word = r_word;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_IDX)
        else $error("read position beyond the table");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_stall))
        else $error("pending output word overwritten");

    a_word_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> o_valid && r_word == temper($past(r_rd_a)))
        else $error("output register did not take the tempered word");

endmodule

@@ hdl/mtwg_ctrl.sv @@
// Controller: sequences seeding, twisting and word output for each request transfer.
module mtwg_ctrl
    import mtwg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_restart,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_BLD_FIRST = 11'b000_0000_0010,
        S_BLD_MUL   = 11'b000_0000_0100,
        S_BLD_ADD   = 11'b000_0000_1000,
        S_TW_PRE    = 11'b000_0001_0000,
        S_TW_LOAD   = 11'b000_0010_0000,
        S_TW_RD     = 11'b000_0100_0000,
        S_TW_WR     = 11'b000_1000_0000,
        S_OUT_RD    = 11'b001_0000_0000,
        S_OUT_LD    = 11'b010_0000_0000,
        S_SPARE     = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_init_pending;
    logic   n_init_pending;
    logic   accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_state        = r_state;
        n_init_pending = r_init_pending;
        o_cmd          = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_restart || r_init_pending) begin
                        n_init_pending = 1'b0;
                        n_state        = S_BLD_FIRST;
                    end else if (i_stat.pos_zero) begin
                        n_state = S_TW_PRE;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            S_BLD_FIRST: begin
                o_cmd.bld_first = 1'b1;
                n_state         = S_BLD_MUL;
            end
            S_BLD_MUL: begin
                o_cmd.bld_mul = 1'b1;
                n_state       = S_BLD_ADD;
            end
            S_BLD_ADD: begin
                o_cmd.bld_add = 1'b1;
                if (i_stat.idx_last) begin
                    o_cmd.pos_clear = 1'b1;
                    n_state         = S_TW_PRE;
                end else begin
                    n_state = S_BLD_MUL;
                end
            end
            S_TW_PRE: begin
                o_cmd.tw_pre = 1'b1;
                n_state      = S_TW_LOAD;
            end
            S_TW_LOAD: begin
                o_cmd.tw_load = 1'b1;
                n_state       = S_TW_RD;
            end
            S_TW_RD: begin
                o_cmd.tw_read = 1'b1;
                n_state       = S_TW_WR;
            end
            S_TW_WR: begin
                o_cmd.tw_write = 1'b1;
                n_state        = i_stat.idx_last ? S_OUT_RD : S_TW_RD;
            end
            S_OUT_RD: begin
                o_cmd.out_read = 1'b1;
                n_state        = S_OUT_LD;
            end
            S_OUT_LD: begin
                // Hold the word read from the table until the output register frees up.
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_init_pending <= 1'b1;
        end else begin
            r_state        <= n_state;
            r_init_pending <= n_init_pending;
        end
    end

    a_restart_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_restart |=> r_state == S_BLD_FIRST)
        else $error("restart transfer did not start a table rebuild");

    a_build_then_twist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BLD_ADD && i_stat.idx_last |=> r_state == S_TW_PRE)
        else $error("table rebuild not followed by a twist pass");

    a_pending_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !r_init_pending)
        else $error("initialization still pending after a transfer");

endmodule
